FILE: rtl/mqtr_pkg.sv
// ----------------------------------------------------------------------------
// mqtr_pkg
// Shared types and constants of the quarter-turn matrix rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package mqtr_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_REG_W = 8;
  localparam int ANG_W     = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LEFT = 2'd3;

  // Item commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [ANG_W-1:0] ANG_0    = 9'd0;
  localparam logic [ANG_W-1:0] ANG_90   = 9'd90;
  localparam logic [ANG_W-1:0] ANG_180  = 9'd180;
  localparam logic [ANG_W-1:0] ANG_270  = 9'd270;
  localparam logic [ANG_W-1:0] ANG_FULL = 9'd360;

  // Effective clockwise rotation; ROT_NONE for angles off the quarter grid.
  typedef enum logic [2:0] {
    ROT_0,
    ROT_90,
    ROT_180,
    ROT_270,
    ROT_NONE
  } rot_t;

  // Operation flags that travel with each queued item.
  typedef struct packed {
    logic is_fetch;
    logic row_end;
    logic last;
  } op_flags_t;

endpackage

`default_nettype wire

FILE: rtl/mqtr_front.sv
// ----------------------------------------------------------------------------
// mqtr_front
// Holds the configuration and the load and output position counters, turns
// each load or on-grid fetch into a store write or read at a computed address.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtr_front #(
  parameter int MAX_DIM = 128,
  parameter int IW      = $clog2(MAX_DIM)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mqtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mqtr_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_cmd,
  input  wire logic [mqtr_pkg::DATA_W-1:0]    in_element,
  output logic                                q_push,
  input  wire logic                           q_full,
  output mqtr_pkg::op_flags_t                 q_flags,
  output logic [2*IW-1:0]                     q_addr,
  output logic [mqtr_pkg::DATA_W-1:0]         q_element
);
  import mqtr_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);

  logic [DIM_REG_W-1:0] cols_r, rows_r;
  logic [ANG_W-1:0]     angle_r;
  logic                 turn_left_r;

  logic [IW-1:0] load_row_r, load_col_r, out_row_r, out_col_r;
  logic [IW-1:0] load_row_nxt, load_col_nxt, out_row_nxt, out_col_nxt;

  logic [DW-1:0]    w, h, orows, ocols, sr, sc;
  logic [ANG_W-1:0] a_red;
  rot_t             rot;
  logic             accept, is_fetch, fetch_ok;
  logic [IW-1:0]    lr, lc, orr, occ;
  logic             row_end, last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= DIM_REG_W'(1);
      rows_r      <= DIM_REG_W'(1);
      angle_r     <= '0;
      turn_left_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS:      cols_r      <= cfg_data[DIM_REG_W-1:0];
        CFG_ROWS:      rows_r      <= cfg_data[DIM_REG_W-1:0];
        CFG_ANGLE:     angle_r     <= cfg_data[ANG_W-1:0];
        CFG_TURN_LEFT: turn_left_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Dimensions out of range act as the nearest legal size.
  always_comb begin
    if (cols_r == '0) w = DW'(1);
    else if (int'(cols_r) > MAX_DIM) w = DW'(MAX_DIM);
    else w = DW'(cols_r);
    if (rows_r == '0) h = DW'(1);
    else if (int'(rows_r) > MAX_DIM) h = DW'(MAX_DIM);
    else h = DW'(rows_r);
  end

  // A counter-clockwise turn is folded into the matching clockwise one.
  always_comb begin
    a_red = (angle_r >= ANG_FULL) ? angle_r - ANG_FULL : angle_r;
    unique case (a_red)
      ANG_0:   rot = ROT_0;
      ANG_90:  rot = turn_left_r ? ROT_270 : ROT_90;
      ANG_180: rot = ROT_180;
      ANG_270: rot = turn_left_r ? ROT_90 : ROT_270;
      default: rot = ROT_NONE;
    endcase
  end

  always_comb begin
    accept   = in_valid && !in_stall;
    is_fetch = (in_cmd == CMD_FETCH);
    fetch_ok = (rot != ROT_NONE);

    if (rot == ROT_0 || rot == ROT_180) begin
      orows = h;
      ocols = w;
    end else begin
      orows = w;
      ocols = h;
    end

    // Positions left beyond the current size restart at the origin.
    if (DW'(load_row_r) >= h || DW'(load_col_r) >= w) begin
      lr = '0;
      lc = '0;
    end else begin
      lr = load_row_r;
      lc = load_col_r;
    end
    if (DW'(out_row_r) >= orows || DW'(out_col_r) >= ocols) begin
      orr = '0;
      occ = '0;
    end else begin
      orr = out_row_r;
      occ = out_col_r;
    end

    unique case (rot)
      ROT_90: begin
        sr = h - DW'(1) - DW'(occ);
        sc = DW'(orr);
      end
      ROT_180: begin
        sr = h - DW'(1) - DW'(orr);
        sc = w - DW'(1) - DW'(occ);
      end
      ROT_270: begin
        sr = DW'(occ);
        sc = w - DW'(1) - DW'(orr);
      end
      default: begin
        sr = DW'(orr);
        sc = DW'(occ);
      end
    endcase

    row_end = (DW'(occ) + DW'(1) == ocols);
    last    = row_end && (DW'(orr) + DW'(1) == orows);

    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    if (accept) begin
      load_row_nxt = lr;
      load_col_nxt = lc;
      if (!is_fetch) begin
        if (DW'(lc) + DW'(1) >= w) begin
          load_col_nxt = '0;
          load_row_nxt = (DW'(lr) + DW'(1) >= h) ? '0 : lr + IW'(1);
        end else begin
          load_col_nxt = lc + IW'(1);
        end
      end else if (fetch_ok) begin
        if (DW'(occ) + DW'(1) >= ocols) begin
          out_col_nxt = '0;
          out_row_nxt = (DW'(orr) + DW'(1) >= orows) ? '0 : orr + IW'(1);
        end else begin
          out_row_nxt = orr;
          out_col_nxt = occ + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
    end else begin
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
    end
  end

  assign in_stall         = q_full;
  assign q_push           = accept && (!is_fetch || fetch_ok);
  assign q_flags.is_fetch = is_fetch;
  assign q_flags.row_end  = is_fetch && row_end;
  assign q_flags.last     = is_fetch && last;
  assign q_addr           = is_fetch ? {sr[IW-1:0], sc[IW-1:0]} : {lr, lc};
  assign q_element        = in_element;

endmodule

`default_nettype wire

FILE: rtl/mqtr_queue.sv
// ----------------------------------------------------------------------------
// mqtr_queue
// Two-entry queue of store operations between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtr_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output logic [W-1:0]      head_data
);

  logic [W-1:0] data_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = data_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) data_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mqtr_back.sv
// ----------------------------------------------------------------------------
// mqtr_back
// Element store and result register: loads write the store, fetches read it
// and hold the element with its flags until the item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtr_back #(
  parameter int AW = 14
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        head_valid,
  input  mqtr_pkg::op_flags_t              head_flags,
  input  wire logic [AW-1:0]               head_addr,
  input  wire logic [mqtr_pkg::DATA_W-1:0] head_element,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mqtr_pkg::DATA_W-1:0]      out_value,
  output logic                             out_row_end,
  output logic                             out_last
);
  import mqtr_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic              res_valid_r, res_valid_nxt;
  logic              row_end_r, last_r;
  logic              wr_en, rd_en, taken;

  // A fetch moves on only when the result register is free by the next edge.
  always_comb begin
    taken         = res_valid_r && !out_stall;
    pop           = head_valid && (!head_flags.is_fetch || !res_valid_r || !out_stall);
    wr_en         = pop && !head_flags.is_fetch;
    rd_en         = pop && head_flags.is_fetch;
    res_valid_nxt = rd_en ? 1'b1 : (taken ? 1'b0 : res_valid_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[head_addr] <= head_element;
    if (rd_en) begin
      rdata_r   <= mem_r[head_addr];
      row_end_r <= head_flags.row_end;
      last_r    <= head_flags.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_valid_r <= 1'b0;
    else        res_valid_r <= res_valid_nxt;
  end

  assign out_valid   = res_valid_r;
  assign out_value   = rdata_r;
  assign out_row_end = row_end_r;
  assign out_last    = last_r;

endmodule

`default_nettype wire

FILE: rtl/matrix_quarter_turn_rotator.sv
// The rotator takes one item per clock cycle while in_stall is low, loads and
// fetches alike, and a fetch result passes through the queue and the result
// register to the output. The rate is set by the single element store, which
// does one write or one read each cycle; a two-entry queue in front of it
// fills during an output stall, and then the input stalls. The store needs
// no clearing pass after reset, so items are taken once reset is released.
// Loads fill the store in row-major order; fetches stream the rotated matrix
// in row-major order and flag each row end and the final element.
// ----------------------------------------------------------------------------
// matrix_quarter_turn_rotator
// Top level: front end, operation queue and store back end.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_quarter_turn_rotator #(
  parameter int MAX_DIM = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mqtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mqtr_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_cmd,
  input  wire logic [mqtr_pkg::DATA_W-1:0]    in_element,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [mqtr_pkg::DATA_W-1:0]         out_value,
  output logic                                out_row_end,
  output logic                                out_last
);
  import mqtr_pkg::*;

  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = 2 * IW;
  localparam int FW = $bits(op_flags_t);
  localparam int QW = FW + AW + DATA_W;

  logic              q_push, q_full, q_pop, head_valid;
  op_flags_t         q_flags, head_flags;
  logic [AW-1:0]     q_addr, head_addr;
  logic [DATA_W-1:0] q_element, head_element;
  logic [QW-1:0]     head_data;

  mqtr_front #(
    .MAX_DIM (MAX_DIM),
    .IW      (IW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_element (in_element),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_flags    (q_flags),
    .q_addr     (q_addr),
    .q_element  (q_element)
  );

  mqtr_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({q_flags, q_addr, q_element}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_flags   = head_data[QW-1 -: FW];
  assign head_addr    = head_data[DATA_W +: AW];
  assign head_element = head_data[DATA_W-1:0];

  mqtr_back #(
    .AW (AW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_flags   (head_flags),
    .head_addr    (head_addr),
    .head_element (head_element),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_row_end  (out_row_end),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

FILE: rtl/mqtr_checker.sv
// ----------------------------------------------------------------------------
// mqtr_checker
// Port-level checks of the rotator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_value,
  input wire logic        out_row_end,
  input wire logic        out_last
);

  // The final element of the matrix always closes an output row.
  a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_row_end)
    else $error("last element without row end");

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A new result follows an accepted item.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding item");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value))
    else $error("stalled result changed");

endmodule

bind matrix_quarter_turn_rotator mqtr_checker u_mqtr_checker (.*);

`default_nettype wire

FILE: sim/matrix_quarter_turn_rotator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_quarter_turn_rotator_tb
// Self-checking bench: loads matrices, streams them back rotated, and
// compares every fetched element and flags against a local predictor or table.
// ----------------------------------------------------------------------------

module matrix_quarter_turn_rotator_tb;
  import mqtr_pkg::*;

  localparam int MAX_DIM      = 128;
  localparam int ITEM_TARGET  = 1350;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 4_000_000;
  localparam int MAX_ERR_LINES = 40;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              row_end;
    logic              last;
  } rot_elem_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // Setting rows pack {turn_left, angle, rows, cols} into the data word.
  typedef struct {
    row_kind_t   kind;
    logic        cmd;
    logic [31:0] data;
    bit          typed;
    logic [31:0] want_value;
    logic        want_row_end;
    logic        want_last;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COLS;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic                 in_cmd    = CMD_LOAD;
  logic [DATA_W-1:0]    in_element = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    out_value;
  logic                 out_row_end;
  logic                 out_last;

  matrix_quarter_turn_rotator #(.MAX_DIM(MAX_DIM)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_element (in_element),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_row_end(out_row_end),
    .out_last   (out_last)
  );

  // Predictor state: registers, positions and the element store.
  logic [7:0]        rot_cols = 8'd1;
  logic [7:0]        rot_rows = 8'd1;
  logic [ANG_W-1:0]  rot_angle = ANG_0;
  logic              rot_left = 1'b0;
  int                load_r = 0, load_c = 0, out_r = 0, out_c = 0;
  logic [DATA_W-1:0] stored_word [MAX_DIM*MAX_DIM];
  bit                stored_valid [MAX_DIM*MAX_DIM];

  rot_elem_t rotated_due[$];
  int        errors = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        settings_used = 0;
  int        in_idle_pct = 0;
  int        out_idle_pct = 0;
  int        idle_in_pct [4] = '{0, 72, 0, 21};
  int        idle_out_pct [4] = '{0, 0, 72, 21};

  dir_row_t dir_plan [30] = '{
    // Reset setting is 1 x 1, no turn: each fetch returns the last load.
    '{ROW_ITEM, CMD_LOAD,  32'h8000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b1, 1'b1},
    '{ROW_ITEM, CMD_LOAD,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1},
    '{ROW_ITEM, CMD_LOAD,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h5555_AAAA, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1},
    '{ROW_CFG,  CMD_LOAD,  {6'd0, 1'b0, ANG_90, 8'd2, 8'd2}, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_LOAD,  32'h0000_0011, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_LOAD,  32'hFFFF_FF22, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_LOAD,  32'h0000_0033, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_LOAD,  32'h8000_0044, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
    // Angle past a full turn, turned the other way.
    '{ROW_CFG,  CMD_LOAD,  {6'd0, 1'b1, ANG_90 + ANG_FULL, 8'd2, 8'd2}, 1'b0, 32'h0,
      1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
    // Off the quarter grid: fetch gives nothing, load still lands.
    '{ROW_CFG,  CMD_LOAD,  {6'd0, 1'b0, 9'd45, 8'd2, 8'd2}, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_LOAD,  32'h0000_0005, 1'b0, 32'h0, 1'b0, 1'b0},
    // Zero dimensions act as one; both positions lie outside and restart.
    '{ROW_CFG,  CMD_LOAD,  {6'd0, 1'b0, ANG_180, 8'd0, 8'd0}, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG,  CMD_LOAD,  {6'd0, 1'b0, ANG_270, 8'd1, 8'd3}, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_LOAD,  32'h1234_5678, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_LOAD,  32'hDEAD_BEEF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_LOAD,  32'h0F0F_0F0F, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{ROW_ITEM, CMD_FETCH, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("matrix_quarter_turn_rotator: mismatch");
    $finish;
  end

  function automatic int eff_dim(input logic [7:0] v);
    if (v == 8'd0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic rot_t eff_rot();
    int a;
    a = int'(rot_angle) % int'(ANG_FULL);
    if (a % int'(ANG_90) != 0) return ROT_NONE;
    if (rot_left) a = (int'(ANG_FULL) - a) % int'(ANG_FULL);
    case (a)
      int'(ANG_0):   return ROT_0;
      int'(ANG_90):  return ROT_90;
      int'(ANG_180): return ROT_180;
      default:       return ROT_270;
    endcase
  endfunction

  function automatic void step_pos(inout int r, inout int c, input int nr, input int nc);
    if (c + 1 >= nc) begin
      c = 0;
      r = (r + 1 >= nr) ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
  endfunction

  // Store index that the next fetch reads, or -1 when a fetch gives nothing.
  function automatic int fetch_source(output int orow, output int ocol,
                                      output int orows, output int ocols);
    int   w, h;
    rot_t r;
    w = eff_dim(rot_cols);
    h = eff_dim(rot_rows);
    r = eff_rot();
    orow = out_r;
    ocol = out_c;
    orows = h;
    ocols = w;
    if (r == ROT_NONE) return -1;
    if (r == ROT_90 || r == ROT_270) begin
      orows = w;
      ocols = h;
    end
    if (orow >= orows || ocol >= ocols) begin
      orow = 0;
      ocol = 0;
    end
    case (r)
      ROT_0:   return orow * MAX_DIM + ocol;
      ROT_90:  return (h - 1 - ocol) * MAX_DIM + orow;
      ROT_180: return (h - 1 - orow) * MAX_DIM + (w - 1 - ocol);
      default: return ocol * MAX_DIM + (w - 1 - orow);
    endcase
  endfunction

  // Advances the predictor by one accepted item; returns 1 with a result.
  function automatic bit rotate_step(input logic cmd, input logic [DATA_W-1:0] elem,
                                     output rot_elem_t res);
    int w, h, idx, orow, ocol, orows, ocols;
    w = eff_dim(rot_cols);
    h = eff_dim(rot_rows);
    res = '0;
    if (load_r >= h || load_c >= w) begin
      load_r = 0;
      load_c = 0;
    end
    if (cmd == CMD_LOAD) begin
      idx = load_r * MAX_DIM + load_c;
      stored_word[idx] = elem;
      stored_valid[idx] = 1'b1;
      step_pos(load_r, load_c, h, w);
      return 1'b0;
    end
    idx = fetch_source(orow, ocol, orows, ocols);
    if (idx < 0) return 1'b0;
    res.value = stored_word[idx];
    res.row_end = (ocol + 1 == ocols);
    res.last = res.row_end && (orow + 1 == orows);
    out_r = orow;
    out_c = ocol;
    step_pos(out_r, out_c, orows, ocols);
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] rand_element();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly small sizes; now and then one side at or beyond the maximum.
  function automatic logic [7:0] pick_dim();
    case ($urandom_range(31))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd128;
      3:       return 8'($urandom_range(129, 254));
      4:       return 8'($urandom_range(7, 127));
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [ANG_W-1:0] pick_angle();
    logic [ANG_W-1:0] a;
    case ($urandom_range(3))
      0:       a = ANG_0;
      1:       a = ANG_90;
      2:       a = ANG_180;
      default: a = ANG_270;
    endcase
    if ($urandom_range(3) == 0 && int'(a) + int'(ANG_FULL) < (1 << ANG_W))
      a = a + ANG_FULL;
    if ($urandom_range(9) == 0) a = ANG_W'($urandom_range((1 << ANG_W) - 1));
    return a;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_ERR_LINES) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic send_item(input logic cmd, input logic [DATA_W-1:0] elem,
                           input bit typed, input rot_elem_t want);
    rot_elem_t res;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_element <= elem;
    do @(posedge clk); while (in_stall);
    if (rotate_step(cmd, elem, res)) begin
      rotated_due.push_back(typed ? want : res);
      items_sent++;
    end else if (cmd == CMD_LOAD) begin
      items_sent++;
    end
  endtask

  // Lets the block go quiet so the registers may be rewritten.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rotated_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Unused upper data bits are randomized; the block must ignore them.
  task automatic write_config(input logic [7:0] cols, input logic [7:0] rows,
                              input logic [ANG_W-1:0] ang, input logic tl);
    cfg_we <= 1'b1;
    cfg_index <= CFG_COLS;
    cfg_data <= {1'($urandom_range(1)), cols};
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_data <= {1'($urandom_range(1)), rows};
    @(posedge clk);
    cfg_index <= CFG_ANGLE;
    cfg_data <= ang;
    @(posedge clk);
    cfg_index <= CFG_TURN_LEFT;
    cfg_data <= {8'($urandom), tl};
    @(posedge clk);
    cfg_we <= 1'b0;
    rot_cols = cols;
    rot_rows = rows;
    rot_angle = ang;
    rot_left = tl;
    settings_used++;
  endtask

  task automatic check_result();
    rot_elem_t want;
    if (rotated_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result, value %h", out_value));
      return;
    end
    want = rotated_due.pop_front();
    results_checked++;
    if (out_value !== want.value)
      report_mismatch($sformatf("result %0d: value %h, expected %h",
                                results_checked, out_value, want.value));
    if (out_row_end !== want.row_end)
      report_mismatch($sformatf("result %0d: row_end %b, expected %b",
                                results_checked, out_row_end, want.row_end));
    if (out_last !== want.last)
      report_mismatch($sformatf("result %0d: last %b, expected %b",
                                results_checked, out_last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  initial begin
    rot_elem_t        want;
    logic [7:0]       cols_v, rows_v;
    int               area, n, idx, orow, ocol, orows, ocols;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == ROW_CFG) begin
        wait_drained();
        write_config(dir_plan[i].data[7:0], dir_plan[i].data[15:8],
                     dir_plan[i].data[24:16], dir_plan[i].data[25]);
      end else begin
        want.value = dir_plan[i].want_value;
        want.row_end = dir_plan[i].want_row_end;
        want.last = dir_plan[i].want_last;
        send_item(dir_plan[i].cmd, dir_plan[i].data, dir_plan[i].typed, want);
      end
    end

    // Each setting: a full load of the matrix, then a fetch stream with
    // stray loads mixed in. Some settings skip the load to exercise stale
    // contents and positions left over from the previous size.
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      in_idle_pct = idle_in_pct[settings_used % 4];
      out_idle_pct = idle_out_pct[settings_used % 4];
      cols_v = pick_dim();
      if (eff_dim(cols_v) > 6) begin
        rows_v = 8'($urandom_range(2));
      end else begin
        rows_v = pick_dim();
        if (eff_dim(rows_v) > 6) cols_v = 8'($urandom_range(2));
      end
      write_config(cols_v, rows_v, pick_angle(), 1'($urandom_range(1)));
      area = eff_dim(rot_cols) * eff_dim(rot_rows);
      if ($urandom_range(99) < 85)
        repeat (area) send_item(CMD_LOAD, rand_element(), 1'b0, '0);
      if (eff_rot() == ROT_NONE) n = $urandom_range(1, 3);
      else if (area > 32) n = area + $urandom_range(4);
      else n = area * $urandom_range(1, 3) + $urandom_range(3);
      repeat (n) begin
        idx = fetch_source(orow, ocol, orows, ocols);
        // A fetch that would read a never-written entry becomes a load.
        if ($urandom_range(99) < 12 || (idx >= 0 && !stored_valid[idx]))
          send_item(CMD_LOAD, rand_element(), 1'b0, '0);
        else
          send_item(CMD_FETCH, $urandom, 1'b0, '0);
      end
    end

    wait_drained();
    $display("Sent %0d items across %0d register settings; checked %0d rotated elements.",
             items_sent, settings_used, results_checked);
    if (errors == 0) begin
      $display("matrix_quarter_turn_rotator: match");
    end else begin
      $display("matrix_quarter_turn_rotator: mismatch");
    end
    $finish;
  end

endmodule
